// File: src/bmp_palette_to_rgb565_decoder_macros.svh
// Assertion macros for the BMP palette decoder.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef BMP_PALETTE_TO_RGB565_DECODER_MACROS_SVH
`define BMP_PALETTE_TO_RGB565_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPTR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle invariant violated");

// Next-cycle implication, checked outside reset.
`define BPTR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle invariant violated");

`endif

// File: src/bptr_pkg.sv
// Shared types and constants of the BMP palette decoder.
// No dependencies; used by the top level.
package bptr_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int PALETTE_DEPTH = 256;

	localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	localparam logic [15:0] SIG_BM = 16'h4D42;

	// Header byte positions where a field is complete.
	localparam logic [5:0] IDX_SIG    = 6'd1;
	localparam logic [5:0] IDX_WIDTH  = 6'd21;
	localparam logic [5:0] IDX_HEIGHT = 6'd25;
	localparam logic [5:0] IDX_BPP    = 6'd29;
	localparam logic [5:0] IDX_USED   = 6'd49;
	localparam logic [5:0] IDX_LAST   = 6'd53;

	// Result status codes.
	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_SIG   = 2'd1;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
	localparam logic [1:0] ST_BAD_DIMS  = 2'd3;

	// Pixel depth codes.
	localparam logic [1:0] DC_1BPP = 2'd0;
	localparam logic [1:0] DC_4BPP = 2'd1;
	localparam logic [1:0] DC_8BPP = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PALETTE,
		PH_PIXELS,
		PH_PAD,
		PH_DONE
	} phase_t;

endpackage

// File: src/bptr_byte_if.sv
// Input channel of the BMP palette decoder: one file byte per beat.
// No dependencies.
interface bptr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

// File: src/bptr_pixel_if.sv
// Output channel of the BMP palette decoder: one pixel or error result per beat.
// No dependencies.
interface bptr_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_color;
	logic [9:0]  pixel_column;
	logic [9:0]  pixel_row;
	logic [1:0]  status;
	logic        last_of_image;

	modport source (output valid, output pixel_color, output pixel_column,
		output pixel_row, output status, output last_of_image, input ready);
	modport sink (input valid, input pixel_color, input pixel_column,
		input pixel_row, input status, input last_of_image, output ready);
endinterface

// File: src/bmp_palette_to_rgb565_decoder.sv
// BMP palette decoder: takes a palettized BMP file one byte per beat on byte_in
// and gives one RGB565 pixel per beat on pixel_out, with its column, its row
// (flipped, since BMP rows are stored bottom up) and a last flag on the final
// pixel. A beat with start_of_file high restarts the parser on header byte 0.
// Header and palette bytes give no result, except a bad signature
// (status 1), an unsupported depth (status 2) or dimensions out of
// range (status 3), which give one error beat with last set; input
// is then ignored until the next start. A pixel byte yields up to 8
// pixels at 1 bpp, 2 at 4 bpp, 1 at 8 bpp, each looked up at the single
// read port of the color table, which serves one lookup per cycle unless
// the output stalls. A result passes the pixel expander, the table read
// and the output register. The color table is a 256 x 16 synchronous
// memory; per-entry valid bits make it read as zero after reset until an
// entry is loaded, so no clearing pass is needed. Entries persist across files.
// Depends on bptr_pkg, bptr_byte_if, bptr_pixel_if and the macros header.
`include "bmp_palette_to_rgb565_decoder_macros.svh"

module bmp_palette_to_rgb565_decoder (
	input logic           clk,
	input logic           arst_n,
	bptr_byte_if.sink     byte_in,
	bptr_pixel_if.source  pixel_out
);
	import bptr_pkg::*;

	// Parser state
	phase_t              phase_q, phase_d;
	logic [5:0]          hdr_idx_q, hdr_idx_d;
	logic [31:0]         acc_q, acc_d;
	logic [DIM_W-1:0]    width_q, width_d;
	logic [HGT_W-1:0]    height_q, height_d;
	logic                width_bad_q, width_bad_d;
	logic                height_bad_q, height_bad_d;
	logic [1:0]          depth_q, depth_d;
	logic                depth_ok_q, depth_ok_d;
	logic [PAL_AW-1:0]   pal_top_q, pal_top_d;
	logic [PAL_AW:0]     pal_idx_q, pal_idx_d;
	logic [1:0]          pal_phase_q, pal_phase_d;
	logic [15:0]         partial_q, partial_d;
	logic [DIM_W-1:0]    col_q, col_d;
	logic [HGT_W-1:0]    row_q, row_d;
	logic [1:0]          rbp_q, rbp_d;

	// Stage 1: pixel expander, stage 2: table read, stage 3: output register
	logic                gen_v_s1;
	logic [7:0]          gen_byte_s1;
	logic [1:0]          gen_depth_s1;
	logic [3:0]          gen_left_s1;
	logic [9:0]          gen_col_s1;
	logic [9:0]          gen_row_s1;
	logic                gen_final_s1;
	logic [1:0]          gen_status_s1;

	logic                rd_v_s2;
	logic [9:0]          rd_col_s2;
	logic [9:0]          rd_row_s2;
	logic [1:0]          rd_status_s2;
	logic                rd_last_s2;
	logic                rd_ok_s2;
	logic [15:0]         rdata_s2;

	logic                out_v_s3;
	logic [15:0]         out_color_s3;
	logic [9:0]          out_col_s3;
	logic [9:0]          out_row_s3;
	logic [1:0]          out_status_s3;
	logic                out_last_s3;

	// Color table
	logic [15:0]             table_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] ent_vld_q;

	// Shared decode of the current beat
	logic                in_acc;
	logic [7:0]          b;
	phase_t              ph_eff;
	logic [5:0]          idx_eff;
	logic [31:0]         acc_nx;
	logic                dok_eff;
	logic                hdr_end;
	logic [1:0]          fail_st;
	logic                hdr_fail;
	logic                pal_wr;
	logic                pal_wr_en;
	logic [PAL_AW:0]     pal_idx_inc;
	logic                pal_done;
	logic [3:0]          per;
	logic [DIM_W-1:0]    rem;
	logic [3:0]          npix;
	logic                row_fits;
	logic                last_row;
	logic                final_pix;
	logic [1:0]          rbp_inc;
	logic                gen_load;
	logic [8:0]          ncolors;
	logic [PAL_AW-1:0]   pix_idx;
	logic                rd_issue;
	logic                s2_adv;

	assign in_acc  = byte_in.valid && byte_in.ready;
	assign b       = byte_in.data_byte;

	// A start beat restarts the header with a clean accumulator.
	assign ph_eff  = byte_in.start_of_file ? PH_HEADER : phase_q;
	assign idx_eff = byte_in.start_of_file ? 6'd0 : hdr_idx_q;
	assign acc_nx  = byte_in.start_of_file ? {b, 24'd0} : {b, acc_q[31:8]};
	assign dok_eff = byte_in.start_of_file ? 1'b0 : depth_ok_q;
	assign hdr_end = (idx_eff == IDX_LAST);

	// Depth error wins over a dimension error.
	always_comb begin
		fail_st = ST_PIXEL;
		if (idx_eff == IDX_SIG && acc_nx[31:16] != SIG_BM) begin
			fail_st = ST_BAD_SIG;
		end else if (hdr_end && !dok_eff) begin
			fail_st = ST_BAD_DEPTH;
		end else if (hdr_end && (width_bad_q || height_bad_q)) begin
			fail_st = ST_BAD_DIMS;
		end
	end
	assign hdr_fail = (ph_eff == PH_HEADER) && (fail_st != ST_PIXEL);

	assign pal_wr      = (ph_eff == PH_PALETTE) && (pal_phase_q == 2'd3);
	assign pal_wr_en   = in_acc && pal_wr;
	assign pal_idx_inc = pal_idx_q + 1'b1;
	assign pal_done    = pal_wr && (pal_idx_inc > {1'b0, pal_top_q});

	always_comb begin
		case (depth_q)
			DC_1BPP: per = 4'd8;
			DC_4BPP: per = 4'd2;
			default: per = 4'd1;
		endcase
	end

	// Pixels left in the row versus pixels in this byte
	assign rem       = width_q - col_q;
	assign row_fits  = (rem <= DIM_W'(per));
	assign npix      = row_fits ? 4'(rem) : per;
	assign last_row  = (row_q == height_q - 1'b1);
	assign final_pix = last_row && row_fits;
	assign rbp_inc   = rbp_q + 2'd1;
	assign gen_load  = hdr_fail || (ph_eff == PH_PIXELS);

	always_comb begin
		case (depth_q)
			DC_1BPP: ncolors = 9'd2;
			DC_4BPP: ncolors = 9'd16;
			default: ncolors = 9'd256;
		endcase
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (in_acc) begin
			case (ph_eff)
				PH_HEADER: begin
					if (hdr_fail) phase_d = PH_DONE;
					else if (hdr_end) phase_d = PH_PALETTE;
					else phase_d = PH_HEADER;
				end
				PH_PALETTE: begin
					phase_d = pal_done ? PH_PIXELS : PH_PALETTE;
				end
				PH_PIXELS: begin
					if (final_pix) phase_d = PH_DONE;
					else if (row_fits) phase_d = (rbp_inc == 2'd0) ? PH_PIXELS : PH_PAD;
					else phase_d = PH_PIXELS;
				end
				PH_PAD: begin
					phase_d = (rbp_inc == 2'd0) ? PH_PIXELS : PH_PAD;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Parser datapath
	always_comb begin
		hdr_idx_d    = hdr_idx_q;
		acc_d        = acc_q;
		width_d      = width_q;
		height_d     = height_q;
		width_bad_d  = width_bad_q;
		height_bad_d = height_bad_q;
		depth_d      = depth_q;
		depth_ok_d   = depth_ok_q;
		pal_top_d    = pal_top_q;
		pal_idx_d    = pal_idx_q;
		pal_phase_d  = pal_phase_q;
		partial_d    = partial_q;
		col_d        = col_q;
		row_d        = row_q;
		rbp_d        = rbp_q;
		if (in_acc) begin
			if (byte_in.start_of_file) begin
				depth_ok_d = 1'b0;
			end
			case (ph_eff)
				PH_HEADER: begin
					hdr_idx_d = idx_eff + 6'd1;
					acc_d     = acc_nx;
					case (idx_eff)
						IDX_WIDTH: begin
							width_d     = DIM_W'(acc_nx);
							width_bad_d = (acc_nx == 32'd0) || (acc_nx > 32'(MAX_WIDTH));
						end
						IDX_HEIGHT: begin
							height_d     = HGT_W'(acc_nx);
							height_bad_d = (acc_nx == 32'd0) || (acc_nx > 32'(MAX_HEIGHT));
						end
						IDX_BPP: begin
							depth_ok_d = 1'b1;
							case (acc_nx[31:16])
								16'd1: depth_d = DC_1BPP;
								16'd4: depth_d = DC_4BPP;
								16'd8: depth_d = DC_8BPP;
								default: begin
									depth_d    = DC_1BPP;
									depth_ok_d = 1'b0;
								end
							endcase
						end
						IDX_USED: begin
							if (acc_nx == 32'd0 || acc_nx > 32'(ncolors))
								pal_top_d = PAL_AW'(ncolors - 9'd1);
							else
								pal_top_d = PAL_AW'(acc_nx - 32'd1);
						end
						IDX_LAST: begin
							if (!hdr_fail) begin
								pal_idx_d   = '0;
								pal_phase_d = 2'd0;
								partial_d   = 16'd0;
							end
						end
						default: ;
					endcase
				end
				PH_PALETTE: begin
					// Pack blue, green, red; the fourth byte is reserved.
					pal_phase_d = pal_phase_q + 2'd1;
					case (pal_phase_q)
						2'd0: partial_d = {11'd0, b[7:3]};
						2'd1: partial_d = partial_q | {5'd0, b[7:2], 5'd0};
						2'd2: partial_d = partial_q | {b[7:3], 11'd0};
						default: begin
							pal_idx_d = pal_idx_inc;
							if (pal_done) begin
								col_d = '0;
								row_d = '0;
								rbp_d = 2'd0;
							end
						end
					endcase
				end
				PH_PIXELS: begin
					if (final_pix) begin
						col_d = col_q + DIM_W'(npix);
					end else if (row_fits) begin
						rbp_d = rbp_inc;
						if (rbp_inc == 2'd0) begin
							col_d = '0;
							row_d = row_q + 1'b1;
						end
					end else begin
						rbp_d = rbp_inc;
						col_d = col_q + DIM_W'(npix);
					end
				end
				PH_PAD: begin
					rbp_d = rbp_inc;
					if (rbp_inc == 2'd0) begin
						col_d = '0;
						row_d = row_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hdr_idx_q    <= '0;
			acc_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			width_bad_q  <= 1'b0;
			height_bad_q <= 1'b0;
			depth_q      <= DC_1BPP;
			depth_ok_q   <= 1'b0;
			pal_top_q    <= '0;
			pal_idx_q    <= '0;
			pal_phase_q  <= 2'd0;
			partial_q    <= '0;
			col_q        <= '0;
			row_q        <= '0;
			rbp_q        <= 2'd0;
		end else begin
			phase_q      <= phase_d;
			hdr_idx_q    <= hdr_idx_d;
			acc_q        <= acc_d;
			width_q      <= width_d;
			height_q     <= height_d;
			width_bad_q  <= width_bad_d;
			height_bad_q <= height_bad_d;
			depth_q      <= depth_d;
			depth_ok_q   <= depth_ok_d;
			pal_top_q    <= pal_top_d;
			pal_idx_q    <= pal_idx_d;
			pal_phase_q  <= pal_phase_d;
			partial_q    <= partial_d;
			col_q        <= col_d;
			row_q        <= row_d;
			rbp_q        <= rbp_d;
		end
	end

	// Pipeline handshakes: advance a stage when the one ahead is free or drains.
	assign s2_adv   = !out_v_s3 || pixel_out.ready;
	assign rd_issue = gen_v_s1 && (!rd_v_s2 || s2_adv);

	// Take a new byte while the expander is empty or on its last lookup.
	assign byte_in.ready = !gen_v_s1 || (rd_issue && gen_left_s1 == 4'd1);

	// Palette index from the top bits of the pending byte
	always_comb begin
		case (gen_depth_s1)
			DC_1BPP: pix_idx = PAL_AW'(gen_byte_s1[7]);
			DC_4BPP: pix_idx = PAL_AW'(gen_byte_s1[7:4]);
			default: pix_idx = PAL_AW'(gen_byte_s1);
		endcase
	end

	// Stage 1: hold the byte and step one pixel per lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_v_s1 <= 1'b0;
		end else if (in_acc && gen_load) begin
			gen_v_s1 <= 1'b1;
		end else if (rd_issue && gen_left_s1 == 4'd1) begin
			gen_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && gen_load) begin
			gen_byte_s1   <= b;
			gen_depth_s1  <= depth_q;
			gen_left_s1   <= hdr_fail ? 4'd1 : npix;
			gen_col_s1    <= 10'(col_q);
			gen_row_s1    <= 10'(height_q - 1'b1 - row_q);
			gen_final_s1  <= hdr_fail ? 1'b1 : final_pix;
			gen_status_s1 <= hdr_fail ? fail_st : ST_PIXEL;
		end else if (rd_issue) begin
			gen_left_s1 <= gen_left_s1 - 4'd1;
			gen_col_s1  <= gen_col_s1 + 10'd1;
			case (gen_depth_s1)
				DC_1BPP: gen_byte_s1 <= {gen_byte_s1[6:0], 1'b0};
				DC_4BPP: gen_byte_s1 <= {gen_byte_s1[3:0], 4'd0};
				default: gen_byte_s1 <= gen_byte_s1;
			endcase
		end
	end

	// Color table: one write port for palette loads, one registered read port.
	// Loads and lookups never overlap: a file's palette ends before its pixels.
	always_ff @(posedge clk) begin
		if (pal_wr_en) begin
			table_mem[pal_idx_q[PAL_AW-1:0]] <= partial_q;
		end
		if (rd_issue) begin
			rdata_s2 <= table_mem[pix_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (pal_wr_en) begin
			ent_vld_q[pal_idx_q[PAL_AW-1:0]] <= 1'b1;
		end
	end

	// Stage 2: metadata beside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s2 <= 1'b0;
		end else if (rd_issue) begin
			rd_v_s2 <= 1'b1;
		end else if (s2_adv) begin
			rd_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_col_s2    <= (gen_status_s1 == ST_PIXEL) ? gen_col_s1 : 10'd0;
			rd_row_s2    <= (gen_status_s1 == ST_PIXEL) ? gen_row_s1 : 10'd0;
			rd_status_s2 <= gen_status_s1;
			rd_last_s2   <= gen_final_s1 && (gen_left_s1 == 4'd1);
			rd_ok_s2     <= (gen_status_s1 == ST_PIXEL) && ent_vld_q[pix_idx];
		end
	end

	// Stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s3 <= 1'b0;
		end else if (rd_v_s2 && s2_adv) begin
			out_v_s3 <= 1'b1;
		end else if (pixel_out.ready) begin
			out_v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s2 && s2_adv) begin
			out_color_s3  <= rd_ok_s2 ? rdata_s2 : 16'd0;
			out_col_s3    <= rd_col_s2;
			out_row_s3    <= rd_row_s2;
			out_status_s3 <= rd_status_s2;
			out_last_s3   <= rd_last_s2;
		end
	end

	assign pixel_out.valid         = out_v_s3;
	assign pixel_out.pixel_color   = out_color_s3;
	assign pixel_out.pixel_column  = out_col_s3;
	assign pixel_out.pixel_row     = out_row_s3;
	assign pixel_out.status        = out_status_s3;
	assign pixel_out.last_of_image = out_last_s3;

	`BPTR_ASSERT_NOW(a_gen_count, gen_v_s1, gen_left_s1 != 4'd0)
	`BPTR_ASSERT_NOW(a_load_lookup_apart, pal_wr_en, !rd_issue)
	`BPTR_ASSERT_NOW(a_col_in_row, phase_q == PH_PIXELS, col_q < width_q)
	`BPTR_ASSERT_NOW(a_err_beat, pixel_out.valid && pixel_out.status != ST_PIXEL, pixel_out.last_of_image && pixel_out.pixel_color == 16'd0)
	`BPTR_ASSERT_NEXT(a_issue_fills, rd_issue, rd_v_s2)

endmodule
